### hdl/fdi_pkg.sv
// Shared constants, types and a helper function of the interpolated feedback delay.
`timescale 1ns / 1ps
`default_nettype none

package fdi_pkg;

    // Geometry of the delay memory. DEPTH must be a power of two.
    localparam int DEPTH     = 131072;
    localparam int CHANNELS  = 2;
    localparam int AW        = $clog2(DEPTH);

    // Sample and fixed-point formats.
    localparam int SW        = 24;
    localparam int SPAN_W    = SW + 1;
    localparam int EXT_W     = SW + 2;
    localparam int FRAC_W    = 24;
    localparam int SD_W      = AW + FRAC_W;
    localparam int D_W       = SD_W + 1;
    localparam int LO_W      = 21;
    localparam int MUL_W     = 26;
    localparam int P_W       = 2 * MUL_W;
    localparam int ACC_W     = (AW + 42 > P_W) ? AW + 42 : P_W + 1;
    localparam int Q15_SHIFT = 15;

    // Register and stream field widths.
    localparam int TGT_W     = 33;
    localparam int FB_W      = 15;
    localparam int MIX_W     = 16;
    localparam int NCH_W     = 2;
    localparam int CMP_W     = (AW + 16 > TGT_W) ? AW + 16 : TGT_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = TGT_W;
    localparam int TDATA_W   = 2 * SW;

    // Arithmetic constants.
    localparam int SLEW_Q24  = 25166;
    localparam int HALF24    = 1 << 23;
    localparam int HALF15    = 1 << 14;
    localparam int FB_MAX    = 31129;
    localparam int MIX_MAX   = 32768;
    localparam int SMAX      = 8388607;
    localparam int SMIN      = -8388608;

    // Reset values.
    localparam logic [TGT_W-1:0] TGT_RST = TGT_W'(1258291200);
    localparam logic [FB_W-1:0]  FB_RST  = FB_W'(11469);
    localparam logic [MIX_W-1:0] MIX_RST = MIX_W'(11469);
    localparam logic [NCH_W-1:0] NCH_RST = NCH_W'(2);
    localparam int SD_RST_INT = (DEPTH - 1 < 19200) ? DEPTH - 1 : 19200;
    localparam logic [SD_W-1:0]  SD_RST  = {AW'(SD_RST_INT), FRAC_W'(0)};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY_TARGET,
        CFG_FEEDBACK_GAIN,
        CFG_MIX_GAIN,
        CFG_ACTIVE_CHANNELS
    } t_cfg_idx;

    typedef struct packed {
        logic [TGT_W-1:0] delay_target;
        logic [FB_W-1:0]  feedback_gain;
        logic [MIX_W-1:0] mix_gain;
        logic [NCH_W-1:0] active_channels;
    } t_cfg;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CLR,
        OP_LOAD,
        OP_PREP,
        OP_SLEW_LO,
        OP_SLEW_HI,
        OP_SLEW_SUM,
        OP_SLEW_UPD,
        OP_POS,
        OP_RD_A,
        OP_RD_B,
        OP_DIFF,
        OP_INT_MUL,
        OP_INT_ADD,
        OP_DRY_MUL,
        OP_WET_MUL,
        OP_FB_MUL,
        OP_WRITE,
        OP_OUT
    } t_op;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_SLEW_LO,
        ST_SLEW_HI,
        ST_SLEW_SUM,
        ST_SLEW_UPD,
        ST_POS,
        ST_RD_A,
        ST_RD_B,
        ST_DIFF,
        ST_INT_MUL,
        ST_INT_ADD,
        ST_DRY_MUL,
        ST_WET_MUL,
        ST_FB_MUL,
        ST_WRITE,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_op  op;
        logic ch;
    } t_cmd;

    typedef struct packed {
        logic wp_last;
        logic two_ch;
        logic out_free;
    } t_stat;

    // Saturate a wide signed value to one sample.
    function automatic logic signed [SW-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
        logic signed [SW-1:0] r;
        if (v > ACC_W'(SMAX)) begin
            r = SW'(SMAX);
        end else if (v < ACC_W'(SMIN)) begin
            r = SW'(SMIN);
        end else begin
            r = v[SW-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/fdi_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module fdi_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  wire logic [WIDTH-1:0]           i_wr_data,
    input  wire logic                       i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic      [WIDTH-1:0]           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### hdl/fdi_ctrl.sv
// Sequencer that steps the delay datapath through one frame.
`timescale 1ns / 1ps
`default_nettype none

module fdi_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output fdi_pkg::t_cmd       o_cmd,
    input  wire fdi_pkg::t_stat i_stat
);
    import fdi_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_ch;
    logic   n_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_ch    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ch       = r_ch;
        o_cmd.op   = OP_NOP;
        o_cmd.ch   = r_ch;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.op = OP_CLR;
                if (i_stat.wp_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_ch     = 1'b0;
                    n_state  = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.op = OP_PREP;
                n_state  = ST_SLEW_LO;
            end
            ST_SLEW_LO: begin
                o_cmd.op = OP_SLEW_LO;
                n_state  = ST_SLEW_HI;
            end
            ST_SLEW_HI: begin
                o_cmd.op = OP_SLEW_HI;
                n_state  = ST_SLEW_SUM;
            end
            ST_SLEW_SUM: begin
                o_cmd.op = OP_SLEW_SUM;
                n_state  = ST_SLEW_UPD;
            end
            ST_SLEW_UPD: begin
                o_cmd.op = OP_SLEW_UPD;
                n_state  = ST_POS;
            end
            ST_POS: begin
                o_cmd.op = OP_POS;
                n_state  = ST_RD_A;
            end
            ST_RD_A: begin
                o_cmd.op = OP_RD_A;
                n_state  = ST_RD_B;
            end
            ST_RD_B: begin
                o_cmd.op = OP_RD_B;
                n_state  = ST_DIFF;
            end
            ST_DIFF: begin
                o_cmd.op = OP_DIFF;
                n_state  = ST_INT_MUL;
            end
            ST_INT_MUL: begin
                o_cmd.op = OP_INT_MUL;
                n_state  = ST_INT_ADD;
            end
            ST_INT_ADD: begin
                o_cmd.op = OP_INT_ADD;
                n_state  = ST_DRY_MUL;
            end
            ST_DRY_MUL: begin
                o_cmd.op = OP_DRY_MUL;
                n_state  = ST_WET_MUL;
            end
            ST_WET_MUL: begin
                o_cmd.op = OP_WET_MUL;
                n_state  = ST_FB_MUL;
            end
            ST_FB_MUL: begin
                o_cmd.op = OP_FB_MUL;
                n_state  = ST_WRITE;
            end
            ST_WRITE: begin
                o_cmd.op = OP_WRITE;
                if (!r_ch && i_stat.two_ch) begin
                    n_ch    = 1'b1;
                    n_state = ST_RD_A;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // Hold the finished frame until the output register is free.
                if (i_stat.out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/fdi_dpath.sv
// Datapath: delay memories, smoothed delay, shared multiplier and output register.
`timescale 1ns / 1ps
`default_nettype none

module fdi_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire fdi_pkg::t_cfg                 i_cfg,
    input  wire fdi_pkg::t_cmd                 i_cmd,
    output fdi_pkg::t_stat                     o_stat,
    input  wire logic [fdi_pkg::TDATA_W-1:0]   i_s_tdata,
    input  wire logic                          i_s_tlast,
    output logic      [fdi_pkg::TDATA_W-1:0]   o_m_tdata,
    output logic                               o_m_tlast,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready
);
    import fdi_pkg::*;

    localparam logic [CMP_W-1:0] TGT_LO = CMP_W'(1) << 16;
    localparam logic [CMP_W-1:0] TGT_HI = CMP_W'(DEPTH - 2) << 16;
    localparam logic [SD_W-1:0]  SD_MIN = {AW'(1), FRAC_W'(0)};
    localparam logic [SD_W-1:0]  SD_MAX = {AW'(DEPTH - 1), FRAC_W'(0)};

    // Control state.
    logic [AW-1:0]   r_wp;
    logic [SD_W-1:0] r_sd;
    logic            r_out_valid;

    // Frame payload.
    logic signed [SW-1:0]     r_x0;
    logic signed [SW-1:0]     r_x1;
    logic                     r_last;
    logic signed [D_W-1:0]    r_diff;
    logic [FB_W-1:0]          r_fb;
    logic [MIX_W-1:0]         r_mix;
    logic [MIX_W-1:0]         r_dry;
    logic                     r_two_ch;
    logic signed [P_W-1:0]    r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [SD_W-1:0]          r_pos;
    logic signed [SW-1:0]     r_a;
    logic signed [SPAN_W-1:0] r_span;
    logic signed [SW-1:0]     r_yd;
    logic signed [SW-1:0]     r_res0;
    logic signed [SW-1:0]     r_res1;
    logic signed [SW-1:0]     r_out_l;
    logic signed [SW-1:0]     r_out_r;
    logic                     r_out_last;

    logic [CMP_W-1:0]         tgt_w;
    logic [CMP_W-1:0]         tgt_c;
    logic [SD_W-1:0]          tgt24;
    logic [MIX_W-1:0]         mix_c;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic                     mul_en;
    logic [ACC_W-1:0]         sd_step;
    logic [AW-1:0]            i0;
    logic [AW-1:0]            i1;
    logic signed [SW-1:0]     x_sel;
    logic signed [SW-1:0]     rd_sel;
    logic [SW-1:0]            ram0_q;
    logic [SW-1:0]            ram1_q;
    logic signed [P_W-1:0]    int_rnd;
    logic signed [EXT_W-1:0]  int_sum;
    logic signed [ACC_W-1:0]  wb_sum;
    logic signed [SW-1:0]     wb_val;
    logic signed [SW-1:0]     mix_val;
    logic                     ram_we0;
    logic                     ram_we1;
    logic                     ram_re;
    logic [AW-1:0]            ram_raddr;
    logic [SW-1:0]            ram_wdata;
    logic signed [EXT_W-1:0]  chk_a;
    logic signed [EXT_W-1:0]  chk_b;
    logic signed [EXT_W-1:0]  chk_y;

    // Target clamped to one through depth minus two, widened to 24 fraction bits.
    assign tgt_w = CMP_W'(i_cfg.delay_target);
    assign tgt_c = (tgt_w < TGT_LO) ? TGT_LO : ((tgt_w > TGT_HI) ? TGT_HI : tgt_w);
    assign tgt24 = {tgt_c[AW+15:0], 8'b0};
    assign mix_c = (i_cfg.mix_gain > MIX_W'(MIX_MAX)) ? MIX_W'(MIX_MAX) : i_cfg.mix_gain;

    assign sd_step = r_acc >>> FRAC_W;
    assign i0      = r_pos[SD_W-1:FRAC_W];
    assign i1      = i0 + AW'(1);
    assign x_sel   = i_cmd.ch ? r_x1 : r_x0;
    assign rd_sel  = i_cmd.ch ? ram1_q : ram0_q;

    assign int_rnd = (r_prod + P_W'(HALF24)) >>> FRAC_W;
    assign int_sum = EXT_W'(r_a) + $signed(int_rnd[EXT_W-1:0]);

    // x + round(fb * yd / 2^15) folded into one rounded shift.
    assign wb_sum  = (ACC_W'(x_sel) <<< Q15_SHIFT) + ACC_W'(r_prod) + ACC_W'(HALF15);
    assign wb_val  = sat_sample(wb_sum >>> Q15_SHIFT);
    assign mix_val = sat_sample(r_acc >>> Q15_SHIFT);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (i_cmd.op)
            OP_SLEW_LO: begin
                mul_a = MUL_W'({1'b0, r_diff[LO_W-1:0]});
                mul_b = MUL_W'(SLEW_Q24);
            end
            OP_SLEW_HI: begin
                mul_a = MUL_W'($signed(r_diff[D_W-1:LO_W]));
                mul_b = MUL_W'(SLEW_Q24);
            end
            OP_INT_MUL: begin
                mul_a = MUL_W'(r_span);
                mul_b = MUL_W'({1'b0, r_pos[FRAC_W-1:0]});
            end
            OP_DRY_MUL: begin
                mul_a = MUL_W'({1'b0, r_dry});
                mul_b = MUL_W'(x_sel);
            end
            OP_WET_MUL: begin
                mul_a = MUL_W'({1'b0, r_mix});
                mul_b = MUL_W'(r_yd);
            end
            OP_FB_MUL: begin
                mul_a = MUL_W'({1'b0, r_fb});
                mul_b = MUL_W'(r_yd);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Memory port control: a clear sweep or a channel write both go to the write pointer.
    assign ram_we0   = (i_cmd.op == OP_CLR) || ((i_cmd.op == OP_WRITE) && !i_cmd.ch);
    assign ram_we1   = (i_cmd.op == OP_CLR) || ((i_cmd.op == OP_WRITE) && i_cmd.ch);
    assign ram_wdata = (i_cmd.op == OP_CLR) ? '0 : wb_val;
    assign ram_re    = (i_cmd.op == OP_RD_A) || (i_cmd.op == OP_RD_B);
    assign ram_raddr = (i_cmd.op == OP_RD_B) ? i1 : i0;

    fdi_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_ram0 (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we0),
        .i_wr_addr (r_wp),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram0_q)
    );

    fdi_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_ram1 (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we1),
        .i_wr_addr (r_wp),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram1_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_sd        <= SD_RST;
            r_out_valid <= 1'b0;
        end else begin
            if ((i_cmd.op == OP_CLR) || (i_cmd.op == OP_OUT)) begin
                r_wp <= r_wp + AW'(1);
            end
            if (i_cmd.op == OP_SLEW_UPD) begin
                r_sd <= r_sd + sd_step[SD_W-1:0];
            end
            if (i_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        case (i_cmd.op)
            OP_LOAD: begin
                r_x0   <= i_s_tdata[SW-1:0];
                r_x1   <= i_s_tdata[2*SW-1:SW];
                r_last <= i_s_tlast;
            end
            OP_PREP: begin
                r_diff   <= $signed({1'b0, tgt24}) - $signed({1'b0, r_sd});
                r_fb     <= (i_cfg.feedback_gain > FB_W'(FB_MAX)) ? FB_W'(FB_MAX)
                                                                  : i_cfg.feedback_gain;
                r_mix    <= mix_c;
                r_dry    <= MIX_W'(MIX_MAX) - mix_c;
                r_two_ch <= (CHANNELS > 1) && (i_cfg.active_channels >= NCH_W'(2));
            end
            OP_SLEW_HI: begin
                r_acc <= ACC_W'(r_prod);
            end
            OP_SLEW_SUM: begin
                r_acc <= r_acc + (ACC_W'(r_prod) <<< LO_W) + ACC_W'(HALF24);
            end
            OP_POS: begin
                r_pos <= {r_wp, FRAC_W'(0)} - r_sd;
            end
            OP_RD_B: begin
                r_a <= rd_sel;
            end
            OP_DIFF: begin
                r_span <= SPAN_W'(rd_sel) - SPAN_W'(r_a);
            end
            OP_INT_ADD: begin
                r_yd <= sat_sample(ACC_W'(int_sum));
            end
            OP_WET_MUL: begin
                r_acc <= ACC_W'(r_prod) + ACC_W'(HALF15);
            end
            OP_FB_MUL: begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            OP_WRITE: begin
                if (i_cmd.ch) begin
                    r_res1 <= mix_val;
                end else begin
                    r_res0 <= mix_val;
                end
            end
            OP_OUT: begin
                r_out_l    <= r_res0;
                r_out_r    <= r_two_ch ? r_res1 : '0;
                r_out_last <= r_last;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.wp_last  = (r_wp == AW'(DEPTH - 1));
    assign o_stat.two_ch   = r_two_ch;
    assign o_stat.out_free = !r_out_valid || i_m_tready;

    assign o_m_tdata  = {r_out_r, r_out_l};
    assign o_m_tlast  = r_out_last;
    assign o_m_tvalid = r_out_valid;

    assign chk_a = EXT_W'(r_a);
    assign chk_b = EXT_W'(r_a) + EXT_W'(r_span);
    assign chk_y = EXT_W'(r_yd);

    a_sd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sd >= SD_MIN) && (r_sd <= SD_MAX))
        else $error("smoothed delay left its legal range");

    a_tap_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_RD_A) |-> (i0 != r_wp))
        else $error("interpolation tap reached the write pointer");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_OUT) |-> (!r_out_valid || i_m_tready))
        else $error("result overwrote an output still waiting");

    a_interp_between: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_INT_ADD) |=>
        (((r_span >= 0) && (chk_y >= chk_a) && (chk_y <= chk_b)) ||
         ((r_span < 0) && (chk_y <= chk_a) && (chk_y >= chk_b))))
        else $error("interpolated sample outside its two taps");

endmodule

`default_nettype wire

### hdl/feedback_delay_interpolated.sv
// Top level of the stereo feedback delay with linear interpolation.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// The slave stream takes one stereo frame per transfer: tdata holds the left sample in
// bits 23:0 and the right sample in bits 47:24, and tlast marks the last frame of a block.
// The master stream returns one mixed frame per input frame in the same layout, with tlast
// copied from the input. The configuration channel writes one register per transfer:
// index 0 delay target (Q17.16), 1 feedback gain, 2 wet mix gain, 3 active channel count.
// Write registers only while no frame is in flight.
// After reset the block sweeps the delay memories to zero, one address per cycle, and
// s_axis_tready stays low during that sweep.
// The sequencer takes a new input frame only once the previous one has moved into the
// output register. Each frame's steps run one after another on the single shared
// multiplier (four products per channel frame plus two for the delay slew) and the
// two registered reads of each channel's memory. A finished frame waits in the output
// register, so the next input frame is taken while the receiver stalls; a second
// finished frame holds the sequencer until the output register drains.

module feedback_delay_interpolated (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Configuration write channel.
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [fdi_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [fdi_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    // Input frames.
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [fdi_pkg::TDATA_W-1:0]     s_axis_tdata,  // sample_left, sample_right
    input  wire logic                            s_axis_tlast,  // block_last
    // Output frames.
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [fdi_pkg::TDATA_W-1:0]     m_axis_tdata,  // out_left, out_right
    output logic                                 m_axis_tlast   // block_end
);
    import fdi_pkg::*;

    t_cfg  r_cfg;
    t_cmd  cmd;
    t_stat stat;

    // The register file always takes writes; it is only read while a frame runs.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delay_target    <= TGT_RST;
            r_cfg.feedback_gain   <= FB_RST;
            r_cfg.mix_gain        <= MIX_RST;
            r_cfg.active_channels <= NCH_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DELAY_TARGET: begin
                    r_cfg.delay_target <= i_cfg_data[TGT_W-1:0];
                end
                CFG_FEEDBACK_GAIN: begin
                    r_cfg.feedback_gain <= i_cfg_data[FB_W-1:0];
                end
                CFG_MIX_GAIN: begin
                    r_cfg.mix_gain <= i_cfg_data[MIX_W-1:0];
                end
                CFG_ACTIVE_CHANNELS: begin
                    r_cfg.active_channels <= i_cfg_data[NCH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The sequencer owns the input handshake and walks the datapath through each frame.
    fdi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // The datapath holds the memories, the delay state and the output register.
    fdi_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tlast  (s_axis_tlast),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready)
    );

endmodule

`default_nettype wire

### tb/tb_feedback_delay_interpolated.sv
// Self-checking testbench for the interpolated stereo feedback delay.
`timescale 1ns / 1ps

// One stereo frame as it travels on either stream, tlast on top of tdata.
typedef struct packed {
    logic               last;
    logic signed [23:0] right;
    logic signed [23:0] left;
} t_stereo_frame;

// Tracks the delay lines, the write position and the smoothed delay of the block, and
// keeps the mixed frames that the block still owes.
class delay_line_model;

    int            line_mem [2][fdi_pkg::DEPTH];
    int unsigned   wr_pos;
    longint        smooth_q24;
    logic [32:0]   tgt_reg;
    logic [14:0]   fb_reg;
    logic [15:0]   mix_reg;
    logic [1:0]    nch_reg;
    t_stereo_frame mixed_frames [$];
    int            errors;

    function new();
        longint start_q24;
        longint top_q24;
        start_q24  = longint'(19200) <<< 24;
        top_q24    = longint'(fdi_pkg::DEPTH - 1) <<< 24;
        smooth_q24 = (start_q24 > top_q24) ? top_q24 : start_q24;
        wr_pos     = 0;
        tgt_reg    = fdi_pkg::TGT_RST;
        fb_reg     = fdi_pkg::FB_RST;
        mix_reg    = fdi_pkg::MIX_RST;
        nch_reg    = fdi_pkg::NCH_RST;
        errors     = 0;
    endfunction

    static function longint clip24(longint v);
        if (v > longint'(fdi_pkg::SMAX)) begin
            return longint'(fdi_pkg::SMAX);
        end
        if (v < longint'(fdi_pkg::SMIN)) begin
            return longint'(fdi_pkg::SMIN);
        end
        return v;
    endfunction

    // Round half up, then drop n fraction bits (arithmetic shift floors).
    static function longint round_drop(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function void write_reg(fdi_pkg::t_cfg_idx idx, logic [32:0] value);
        case (idx)
            fdi_pkg::CFG_DELAY_TARGET:    tgt_reg = value;
            fdi_pkg::CFG_FEEDBACK_GAIN:   fb_reg  = value[14:0];
            fdi_pkg::CFG_MIX_GAIN:        mix_reg = value[15:0];
            fdi_pkg::CFG_ACTIVE_CHANNELS: nch_reg = value[1:0];
            default: ;
        endcase
    endfunction

    // Advance the delay by one frame and queue the mixed frame the block must return.
    function void take_frame(t_stereo_frame dry_in);
        longint        span;
        longint        tgt;
        longint        fb;
        longint        mix;
        longint        dry;
        longint        x;
        longint        pos;
        longint        p;
        longint        frac;
        longint        a;
        longint        b;
        longint        yd;
        longint        y;
        int            nch;
        int unsigned   i0;
        int unsigned   i1;
        t_stereo_frame res;

        span = longint'(fdi_pkg::DEPTH) <<< 24;
        tgt  = longint'(tgt_reg);
        if (tgt < (longint'(1) <<< 16)) begin
            tgt = longint'(1) <<< 16;
        end
        if (tgt > (longint'(fdi_pkg::DEPTH - 2) <<< 16)) begin
            tgt = longint'(fdi_pkg::DEPTH - 2) <<< 16;
        end
        tgt = tgt <<< 8;
        fb  = (fb_reg > fdi_pkg::FB_MAX) ? longint'(fdi_pkg::FB_MAX) : longint'(fb_reg);
        mix = (mix_reg > fdi_pkg::MIX_MAX) ? longint'(fdi_pkg::MIX_MAX) : longint'(mix_reg);
        dry = longint'(fdi_pkg::MIX_MAX) - mix;
        nch = int'(nch_reg);
        if (nch < 1) begin
            nch = 1;
        end
        if (nch > fdi_pkg::CHANNELS) begin
            nch = fdi_pkg::CHANNELS;
        end

        smooth_q24 += round_drop((tgt - smooth_q24) * longint'(fdi_pkg::SLEW_Q24), 24);

        res      = '0;
        res.last = dry_in.last;
        for (int ch = 0; ch < nch; ch++) begin
            x    = (ch == 0) ? dry_in.left : dry_in.right;
            pos  = (longint'(wr_pos) <<< 24) - smooth_q24;
            p    = ((pos % span) + span) % span;
            i0   = int'(p >>> 24);
            frac = p & 64'h0000_0000_00FF_FFFF;
            i1   = (i0 + 1) % fdi_pkg::DEPTH;
            a    = line_mem[ch][i0];
            b    = line_mem[ch][i1];
            yd   = clip24(a + round_drop((b - a) * frac, 24));
            y    = clip24(round_drop(dry * x + mix * yd, 15));
            line_mem[ch][wr_pos] = int'(clip24(x + round_drop(fb * yd, 15)));
            if (ch == 0) begin
                res.left = y[23:0];
            end else begin
                res.right = y[23:0];
            end
        end
        wr_pos = (wr_pos + 1) % fdi_pkg::DEPTH;
        mixed_frames.push_back(res);
    endfunction

    function void check_frame(t_stereo_frame got);
        t_stereo_frame exp_f;
        if (mixed_frames.size() == 0) begin
            $display("%0t: output frame with none expected: left %0d right %0d last %0b",
                     $time, got.left, got.right, got.last);
            errors++;
            return;
        end
        exp_f = mixed_frames.pop_front();
        if (got.left !== exp_f.left) begin
            $display("%0t: out_left expected %0d, got %0d", $time, exp_f.left, got.left);
            errors++;
        end
        if (got.right !== exp_f.right) begin
            $display("%0t: out_right expected %0d, got %0d", $time, exp_f.right, got.right);
            errors++;
        end
        if (got.last !== exp_f.last) begin
            $display("%0t: block_end expected %0b, got %0b", $time, exp_f.last, got.last);
            errors++;
        end
    endfunction

endclass

module tb_feedback_delay_interpolated;

    logic                             i_clk;
    logic                             i_rst_n       = 1'b0;
    logic                             i_cfg_valid   = 1'b0;
    logic                             o_cfg_ready;
    logic [fdi_pkg::CFG_IDX_W-1:0]    i_cfg_index   = '0;
    logic [fdi_pkg::CFG_DAT_W-1:0]    i_cfg_data    = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [fdi_pkg::TDATA_W-1:0]      s_axis_tdata  = '0;
    logic                             s_axis_tlast  = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [fdi_pkg::TDATA_W-1:0]      m_axis_tdata;
    logic                             m_axis_tlast;

    // When clear, both sides run without gaps.
    bit              idle_on = 1'b1;
    delay_line_model echo;

    feedback_delay_interpolated dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The memory sweep after reset alone takes about 1.3 ms.
    initial begin : watchdog
        #12_000_000;
        $display("tb: failure");
        $finish;
    end

    // Every transfer is taken from the values held just before the clock edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                echo.check_frame(t_stereo_frame'({m_axis_tlast, m_axis_tdata}));
            end
            if (s_axis_tvalid && s_axis_tready) begin
                echo.take_frame(t_stereo_frame'({s_axis_tlast, s_axis_tdata}));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                echo.write_reg(fdi_pkg::t_cfg_idx'(i_cfg_index), i_cfg_data);
            end
        end
    end

    initial begin : receiver
        int stall;
        wait (i_rst_n);
        forever begin
            stall = idle_on ? $urandom_range(0, 12) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Valid stays high into the next frame when no gap is drawn.
    task automatic send_frame(input logic [23:0] left, input logic [23:0] right,
                              input logic last);
        int gap;
        gap = idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {right, left};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(input fdi_pkg::t_cfg_idx idx, input logic [32:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_regs(input logic [32:0] tgt, input logic [14:0] fb,
                            input logic [15:0] mix, input logic [1:0] nch);
        write_reg(fdi_pkg::CFG_DELAY_TARGET, tgt);
        write_reg(fdi_pkg::CFG_FEEDBACK_GAIN, 33'(fb));
        write_reg(fdi_pkg::CFG_MIX_GAIN, 33'(mix));
        write_reg(fdi_pkg::CFG_ACTIVE_CHANNELS, 33'(nch));
        i_cfg_valid <= 1'b0;
    endtask

    // Holds the sender off until every owed frame is back, so the block is idle. The first
    // wait lets the scoreboard note the frame taken at the edge the sender just saw.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (echo.mixed_frames.size() != 0);
    endtask

    function automatic logic [23:0] draw_sample();
        case ($urandom_range(0, 9))
            0:       return 24'(fdi_pkg::SMAX);
            1:       return 24'(fdi_pkg::SMIN);
            2:       return 24'($urandom_range(0, 255)) - 24'd128;
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        logic [32:0] tgt;
        logic [14:0] fb;
        logic [15:0] mix;

        echo = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sample extremes under the reset settings; the first frame waits out the memory sweep.
        send_frame(24'(fdi_pkg::SMAX), 24'(fdi_pkg::SMIN), 1'b1);
        send_frame(24'(fdi_pkg::SMIN), 24'(fdi_pkg::SMAX), 1'b0);
        send_frame(24'h000000, 24'hFFFFFF, 1'b1);
        send_frame(24'hFFFFFF, 24'h000000, 1'b0);
        drain();

        // Target below one sample, both gains above their limits, zero channels.
        set_regs(33'd0, 15'h7FFF, 16'hFFFF, 2'd0);
        send_frame(24'(fdi_pkg::SMAX), 24'(fdi_pkg::SMAX), 1'b0);
        send_frame(24'(fdi_pkg::SMIN), 24'(fdi_pkg::SMIN), 1'b1);
        send_frame(24'h000001, 24'h800001, 1'b0);
        drain();

        // Target beyond the memory, gains at their limits, more channels than exist.
        set_regs(33'h1_FFFF_FFFF, 15'(fdi_pkg::FB_MAX), 16'(fdi_pkg::MIX_MAX), 2'd3);
        send_frame(24'(fdi_pkg::SMAX), 24'(fdi_pkg::SMIN), 1'b1);
        send_frame(24'h555555, 24'hAAAAAA, 1'b0);
        send_frame(24'hAAAAAA, 24'h555555, 1'b1);
        drain();

        // Mono, dry only, no feedback: the right output must stay at zero.
        set_regs(33'h1_0000, 15'd0, 16'd0, 2'd1);
        send_frame(24'(fdi_pkg::SMAX), 24'(fdi_pkg::SMAX), 1'b0);
        send_frame(24'(fdi_pkg::SMIN), 24'h123456, 1'b1);
        send_frame(24'h7FFFFE, 24'h800000, 1'b0);
        drain();

        // Random phases. The target stays short so the smoothed delay shrinks until reads
        // reach frames written earlier in the run, which brings feedback and interpolation
        // of real data into play.
        for (int phase = 0; phase < 12; phase++) begin
            case ($urandom_range(0, 9))
                0:       tgt = 33'($urandom_range(0, 65535));
                1:       tgt = 33'($urandom_range(65536, 4000 << 16));
                default: tgt = 33'($urandom_range(65536, 64 << 16));
            endcase
            fb  = ($urandom_range(0, 3) == 0) ? 15'(fdi_pkg::FB_MAX) : 15'($urandom);
            mix = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
            set_regs(tgt, fb, mix, 2'($urandom_range(0, 3)));
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (150) begin
                send_frame(draw_sample(), draw_sample(), ($urandom_range(0, 7) == 0));
            end
            drain();
        end

        repeat (64) @(posedge i_clk);
        if (echo.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
